### design/hcb_pkg.sv
package hcb_pkg;

    // fixed field widths
    localparam int SYM_IN_W = 7;
    localparam int CODE_W   = 64;
    localparam int LEN_W    = 6;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CNT_WR,
        ST_ENC,
        ST_INIT,
        ST_LEAF_RD,
        ST_LEAF_WR,
        ST_DECIDE,
        ST_SCAN,
        ST_MERGE,
        ST_ROOT,
        ST_TRAV_RD,
        ST_TRAV_W0,
        ST_TRAV_W1,
        ST_TBL_RD,
        ST_TBL_WR
    } st_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CNT_RD,
        OP_CNT_WR,
        OP_ENC_RD,
        OP_ENC_OUT,
        OP_BUILD_INIT,
        OP_LEAF_RD,
        OP_LEAF_WR,
        OP_SCAN,
        OP_MERGE,
        OP_ROOT,
        OP_TRAV_RD,
        OP_TRAV_W0,
        OP_TRAV_W1,
        OP_TBL_RD,
        OP_TBL_WR
    } dp_op_t;

    // datapath status toward the controller
    typedef struct packed {
        logic cnt_last;
        logic sym_last;
        logic live_gt1;
        logic live_gt2;
        logic scan_done;
        logic trav_last;
        logic out_free;
    } stat_t;

endpackage

### design/hcb_ctrl.sv
module hcb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            kind,
    output logic            in_ready,
    input  hcb_pkg::stat_t  stat,
    output hcb_pkg::dp_op_t op
);

    hcb_pkg::st_t state_reg;
    hcb_pkg::st_t state_next;
    logic         accept;

    assign in_ready = (state_reg == hcb_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = kind ? hcb_pkg::ST_ENC : hcb_pkg::ST_CNT_WR;
                end
            end
            hcb_pkg::ST_CNT_WR:
                state_next = stat.cnt_last ? hcb_pkg::ST_INIT : hcb_pkg::ST_IDLE;
            hcb_pkg::ST_ENC:
            begin
                if (stat.out_free)
                begin
                    state_next = hcb_pkg::ST_IDLE;
                end
            end
            hcb_pkg::ST_INIT:
                state_next = hcb_pkg::ST_LEAF_RD;
            hcb_pkg::ST_LEAF_RD:
                state_next = hcb_pkg::ST_LEAF_WR;
            hcb_pkg::ST_LEAF_WR:
                state_next = stat.sym_last ? hcb_pkg::ST_DECIDE : hcb_pkg::ST_LEAF_RD;
            hcb_pkg::ST_DECIDE:
                state_next = stat.live_gt1 ? hcb_pkg::ST_SCAN : hcb_pkg::ST_TBL_RD;
            hcb_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = hcb_pkg::ST_MERGE;
                end
            end
            hcb_pkg::ST_MERGE:
                state_next = stat.live_gt2 ? hcb_pkg::ST_SCAN : hcb_pkg::ST_ROOT;
            hcb_pkg::ST_ROOT:
                state_next = hcb_pkg::ST_TRAV_RD;
            hcb_pkg::ST_TRAV_RD:
                state_next = hcb_pkg::ST_TRAV_W0;
            hcb_pkg::ST_TRAV_W0:
                state_next = hcb_pkg::ST_TRAV_W1;
            hcb_pkg::ST_TRAV_W1:
                state_next = stat.trav_last ? hcb_pkg::ST_TBL_RD : hcb_pkg::ST_TRAV_RD;
            hcb_pkg::ST_TBL_RD:
                state_next = hcb_pkg::ST_TBL_WR;
            hcb_pkg::ST_TBL_WR:
                state_next = stat.sym_last ? hcb_pkg::ST_IDLE : hcb_pkg::ST_TBL_RD;
            default:
                state_next = hcb_pkg::ST_IDLE;
        endcase
    end

    // datapath command
    always_comb
    begin
        op = hcb_pkg::OP_NONE;
        unique case (state_reg)
            hcb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op = kind ? hcb_pkg::OP_ENC_RD : hcb_pkg::OP_CNT_RD;
                end
            end
            hcb_pkg::ST_CNT_WR:  op = hcb_pkg::OP_CNT_WR;
            hcb_pkg::ST_ENC:     op = stat.out_free ? hcb_pkg::OP_ENC_OUT : hcb_pkg::OP_NONE;
            hcb_pkg::ST_INIT:    op = hcb_pkg::OP_BUILD_INIT;
            hcb_pkg::ST_LEAF_RD: op = hcb_pkg::OP_LEAF_RD;
            hcb_pkg::ST_LEAF_WR: op = hcb_pkg::OP_LEAF_WR;
            hcb_pkg::ST_DECIDE:  op = hcb_pkg::OP_NONE;
            hcb_pkg::ST_SCAN:    op = hcb_pkg::OP_SCAN;
            hcb_pkg::ST_MERGE:   op = hcb_pkg::OP_MERGE;
            hcb_pkg::ST_ROOT:    op = hcb_pkg::OP_ROOT;
            hcb_pkg::ST_TRAV_RD: op = hcb_pkg::OP_TRAV_RD;
            hcb_pkg::ST_TRAV_W0: op = hcb_pkg::OP_TRAV_W0;
            hcb_pkg::ST_TRAV_W1: op = hcb_pkg::OP_TRAV_W1;
            hcb_pkg::ST_TBL_RD:  op = hcb_pkg::OP_TBL_RD;
            hcb_pkg::ST_TBL_WR:  op = hcb_pkg::OP_TBL_WR;
            default:             op = hcb_pkg::OP_NONE;
        endcase
    end

endmodule

### design/hcb_dp.sv
module hcb_dp #(
    parameter int SYMBOLS      = 128,
    parameter int COUNT_BITS   = 16,
    parameter int MAX_CODE_LEN = 63
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hcb_pkg::dp_op_t              op,
    output hcb_pkg::stat_t               stat,
    input  logic [hcb_pkg::SYM_IN_W-1:0] symbol,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hcb_pkg::CODE_W-1:0]   code_bits,
    output logic [hcb_pkg::LEN_W-1:0]    code_length
);

    localparam int SYM_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int NODES  = 2 * SYMBOLS;
    localparam int NODE_W = $clog2(NODES);
    localparam int WT_W   = COUNT_BITS + SYM_W;
    localparam int DEP_W  = SYM_W;
    localparam int LC_W   = SYM_W + 1;
    localparam int WIDE_W = SYM_W + hcb_pkg::SYM_IN_W;
    localparam int CW     = hcb_pkg::CODE_W;
    localparam int LW     = hcb_pkg::LEN_W;

    // memories
    logic [COUNT_BITS-1:0] hist_mem [SYMBOLS];
    logic [WT_W-1:0]       nw_mem   [NODES];
    logic [SYM_W-1:0]      nk_mem   [NODES];
    logic [2*NODE_W-1:0]   nc_mem   [NODES];
    logic [DEP_W-1:0]      sd_mem   [NODES];
    logic [CW-1:0]         sc_mem   [NODES];
    logic [CW-1:0]         code_mem [SYMBOLS];
    logic [LW-1:0]         len_mem  [SYMBOLS];

    // registered read data
    logic [COUNT_BITS-1:0] hist_q;
    logic [WT_W-1:0]       nw_q;
    logic [SYM_W-1:0]      nk_q;
    logic [2*NODE_W-1:0]   nc_q;
    logic [DEP_W-1:0]      sd_q;
    logic [CW-1:0]         sc_q;
    logic [CW-1:0]         code_q;
    logic [LW-1:0]         len_q;

    // control and scratch registers
    logic [SYMBOLS-1:0]    hist_vld_reg;
    logic [NODES-1:0]      live_reg;
    logic [LC_W-1:0]       live_cnt_reg;
    logic [NODE_W-1:0]     next_reg;
    logic [SYM_W-1:0]      s_reg;
    logic [NODE_W-1:0]     scan_iss_reg;
    logic [NODE_W-1:0]     pidx_reg;
    logic                  pv_reg;
    logic                  live_q_reg;
    logic [NODE_W-1:0]     trav_reg;
    logic                  phase_reg;
    logic                  cnt_last_reg;
    logic                  cnt_ok_reg;
    logic                  cnt_zero_reg;
    logic [SYM_W-1:0]      cnt_addr_reg;
    logic                  enc_ok_reg;
    logic                  tbl_vld_reg;
    logic                  out_vld_reg;
    logic [CW-1:0]         out_bits_reg;
    logic [LW-1:0]         out_len_reg;

    // two smallest nodes of the current scan
    logic                  m1_vld_reg;
    logic                  m2_vld_reg;
    logic [WT_W-1:0]       m1_w_reg;
    logic [WT_W-1:0]       m2_w_reg;
    logic [SYM_W-1:0]      m1_k_reg;
    logic [SYM_W-1:0]      m2_k_reg;
    logic [NODE_W-1:0]     m1_i_reg;
    logic [NODE_W-1:0]     m2_i_reg;

    logic [WIDE_W-1:0]     sym_wide;
    logic [SYM_W-1:0]      sym_addr;
    logic                  sym_ok;
    logic [COUNT_BITS-1:0] cnt_val;
    logic                  hist_we;
    logic                  hist_re;
    logic [SYM_W-1:0]      hist_ra;
    logic                  iss_go;
    logic                  lt1;
    logic                  lt2;
    logic                  tree_ok;
    logic                  tbl_take;
    logic [NODE_W-1:0]     root_idx;
    logic                  sc_we;
    logic [NODE_W-1:0]     sc_wa;
    logic [DEP_W-1:0]      sd_wd;
    logic [CW-1:0]         sc_wd;
    logic [NODE_W-1:0]     sc_ra;

    // symbol decode
    assign sym_wide = {{SYM_W{1'b0}}, symbol};
    assign sym_addr = sym_wide[SYM_W-1:0];
    assign sym_ok   = (sym_wide < WIDE_W'(SYMBOLS));

    assign cnt_val  = cnt_zero_reg ? '0 : hist_q;
    assign hist_we  = (op == hcb_pkg::OP_CNT_WR) && cnt_ok_reg && (cnt_val != '1);
    assign hist_re  = (op == hcb_pkg::OP_CNT_RD) || (op == hcb_pkg::OP_LEAF_RD);
    assign hist_ra  = (op == hcb_pkg::OP_LEAF_RD) ? s_reg : sym_addr;

    // histogram
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[cnt_addr_reg] <= cnt_val + 1'b1;
        end
        if (hist_re)
        begin
            hist_q <= hist_mem[hist_ra];
        end
    end

    assign iss_go   = (op == hcb_pkg::OP_SCAN) && (scan_iss_reg < next_reg);
    assign root_idx = next_reg - 1'b1;
    assign tree_ok  = (next_reg != NODE_W'(SYMBOLS));

    // node weight and key
    always_ff @(posedge clk)
    begin
        if (op == hcb_pkg::OP_LEAF_WR && hist_vld_reg[s_reg])
        begin
            nw_mem[NODE_W'(s_reg)] <= WT_W'(hist_q);
            nk_mem[NODE_W'(s_reg)] <= s_reg;
        end
        else if (op == hcb_pkg::OP_MERGE)
        begin
            nw_mem[next_reg] <= m1_w_reg + m2_w_reg;
            nk_mem[next_reg] <= m1_k_reg;
        end
        if (iss_go)
        begin
            nw_q <= nw_mem[scan_iss_reg];
            nk_q <= nk_mem[scan_iss_reg];
        end
    end

    // node children
    always_ff @(posedge clk)
    begin
        if (op == hcb_pkg::OP_MERGE)
        begin
            nc_mem[next_reg] <= {m1_i_reg, m2_i_reg};
        end
        if (op == hcb_pkg::OP_TRAV_RD)
        begin
            nc_q <= nc_mem[trav_reg];
        end
    end

    // depth and code scratch write port
    always_comb
    begin
        sc_we = 1'b0;
        sc_wa = root_idx;
        sd_wd = '0;
        sc_wd = '0;
        case (op)
            hcb_pkg::OP_ROOT:
            begin
                sc_we = 1'b1;
            end
            hcb_pkg::OP_TRAV_W0:
            begin
                sc_we = 1'b1;
                sc_wa = nc_q[2*NODE_W-1:NODE_W];
                sd_wd = sd_q + 1'b1;
                sc_wd = {sc_q[CW-2:0], 1'b0};
            end
            hcb_pkg::OP_TRAV_W1:
            begin
                sc_we = 1'b1;
                sc_wa = nc_q[NODE_W-1:0];
                sd_wd = sd_q + 1'b1;
                sc_wd = {sc_q[CW-2:0], 1'b1};
            end
            default:
            begin
                sc_we = 1'b0;
            end
        endcase
    end

    assign sc_ra = (op == hcb_pkg::OP_TBL_RD) ? NODE_W'(s_reg) : trav_reg;

    always_ff @(posedge clk)
    begin
        if (sc_we)
        begin
            sd_mem[sc_wa] <= sd_wd;
            sc_mem[sc_wa] <= sc_wd;
        end
        if (op == hcb_pkg::OP_TRAV_RD || op == hcb_pkg::OP_TBL_RD)
        begin
            sd_q <= sd_mem[sc_ra];
            sc_q <= sc_mem[sc_ra];
        end
    end

    // code and length tables
    assign tbl_take = tree_ok && hist_vld_reg[s_reg] && (32'(sd_q) <= MAX_CODE_LEN);

    always_ff @(posedge clk)
    begin
        if (op == hcb_pkg::OP_TBL_WR)
        begin
            code_mem[s_reg] <= tbl_take ? sc_q : '0;
            len_mem[s_reg]  <= tbl_take ? LW'(sd_q) : '0;
        end
        if (op == hcb_pkg::OP_ENC_RD)
        begin
            code_q <= code_mem[sym_addr];
            len_q  <= len_mem[sym_addr];
        end
    end

    // scan compare on (weight, key)
    assign lt1 = !m1_vld_reg || ({nw_q, nk_q} < {m1_w_reg, m1_k_reg});
    assign lt2 = !m2_vld_reg || ({nw_q, nk_q} < {m2_w_reg, m2_k_reg});

    always_ff @(posedge clk)
    begin
        if (pv_reg && live_q_reg)
        begin
            if (lt1)
            begin
                m2_w_reg <= m1_w_reg;
                m2_k_reg <= m1_k_reg;
                m2_i_reg <= m1_i_reg;
                m1_w_reg <= nw_q;
                m1_k_reg <= nk_q;
                m1_i_reg <= pidx_reg;
            end
            else if (lt2)
            begin
                m2_w_reg <= nw_q;
                m2_k_reg <= nk_q;
                m2_i_reg <= pidx_reg;
            end
        end
        if (op == hcb_pkg::OP_CNT_RD)
        begin
            cnt_addr_reg <= sym_addr;
            cnt_ok_reg   <= sym_ok;
            cnt_zero_reg <= !phase_reg || !hist_vld_reg[sym_addr];
        end
        if (op == hcb_pkg::OP_ENC_RD)
        begin
            enc_ok_reg <= sym_ok;
        end
        if (op == hcb_pkg::OP_ENC_OUT)
        begin
            out_bits_reg <= (tbl_vld_reg && enc_ok_reg) ? code_q : '0;
            out_len_reg  <= (tbl_vld_reg && enc_ok_reg) ? len_q : '0;
        end
        if (iss_go)
        begin
            pidx_reg   <= scan_iss_reg;
            live_q_reg <= live_reg[scan_iss_reg];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
            live_reg     <= '0;
            live_cnt_reg <= '0;
            next_reg     <= NODE_W'(SYMBOLS);
            s_reg        <= '0;
            scan_iss_reg <= '0;
            pv_reg       <= 1'b0;
            trav_reg     <= '0;
            phase_reg    <= 1'b0;
            cnt_last_reg <= 1'b0;
            tbl_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
            m1_vld_reg   <= 1'b0;
            m2_vld_reg   <= 1'b0;
        end
        else
        begin
            pv_reg <= iss_go;
            if (iss_go)
            begin
                scan_iss_reg <= scan_iss_reg + 1'b1;
            end
            if (pv_reg && live_q_reg)
            begin
                m1_vld_reg <= 1'b1;
                m2_vld_reg <= m1_vld_reg || (!lt1 && lt2);
            end
            if (op == hcb_pkg::OP_ENC_OUT)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
            case (op)
                hcb_pkg::OP_CNT_RD:
                begin
                    if (!phase_reg)
                    begin
                        hist_vld_reg <= '0;
                    end
                    phase_reg    <= 1'b1;
                    cnt_last_reg <= last;
                end
                hcb_pkg::OP_CNT_WR:
                begin
                    if (hist_we)
                    begin
                        hist_vld_reg[cnt_addr_reg] <= 1'b1;
                    end
                    if (cnt_last_reg)
                    begin
                        phase_reg <= 1'b0;
                    end
                end
                hcb_pkg::OP_BUILD_INIT:
                begin
                    live_reg     <= '0;
                    live_cnt_reg <= '0;
                    next_reg     <= NODE_W'(SYMBOLS);
                    s_reg        <= '0;
                    scan_iss_reg <= '0;
                    m1_vld_reg   <= 1'b0;
                    m2_vld_reg   <= 1'b0;
                end
                hcb_pkg::OP_LEAF_WR:
                begin
                    if (hist_vld_reg[s_reg])
                    begin
                        live_reg[NODE_W'(s_reg)] <= 1'b1;
                        live_cnt_reg             <= live_cnt_reg + 1'b1;
                    end
                    s_reg <= (s_reg == SYM_W'(SYMBOLS - 1)) ? '0 : s_reg + 1'b1;
                end
                hcb_pkg::OP_MERGE:
                begin
                    live_reg[m1_i_reg] <= 1'b0;
                    live_reg[m2_i_reg] <= 1'b0;
                    live_reg[next_reg] <= 1'b1;
                    live_cnt_reg       <= live_cnt_reg - 1'b1;
                    next_reg           <= next_reg + 1'b1;
                    scan_iss_reg       <= '0;
                    m1_vld_reg         <= 1'b0;
                    m2_vld_reg         <= 1'b0;
                end
                hcb_pkg::OP_ROOT:
                begin
                    trav_reg <= root_idx;
                end
                hcb_pkg::OP_TRAV_W1:
                begin
                    trav_reg <= trav_reg - 1'b1;
                end
                hcb_pkg::OP_TBL_WR:
                begin
                    tbl_vld_reg <= 1'b1;
                    s_reg <= (s_reg == SYM_W'(SYMBOLS - 1)) ? '0 : s_reg + 1'b1;
                end
                default:
                begin
                    phase_reg <= phase_reg;
                end
            endcase
        end
    end

    // status
    assign stat.cnt_last  = cnt_last_reg;
    assign stat.sym_last  = (s_reg == SYM_W'(SYMBOLS - 1));
    assign stat.live_gt1  = (live_cnt_reg > LC_W'(1));
    assign stat.live_gt2  = (live_cnt_reg > LC_W'(2));
    assign stat.scan_done = pv_reg && (pidx_reg == root_idx);
    assign stat.trav_last = (trav_reg == NODE_W'(SYMBOLS));
    assign stat.out_free  = !out_vld_reg || out_ready;

    assign out_valid   = out_vld_reg;
    assign code_bits   = out_bits_reg;
    assign code_length = out_len_reg;

endmodule

### design/huffman_code_builder_top.sv
// Channel | Direction | Handshake          | Item fields
// in      | input     | in_valid/in_ready   | kind, symbol, last
// out     | output    | out_valid/out_ready | code_bits, code_length
//
// A count item is a histogram read, then a write back.
// An encode item is a table read, then any wait for the output register to free.
// The count item marked last starts a build: a leaf pass and a table pass over all
// symbols, a serial minimum scan over the node memory for each merge, and a code
// walk over the internal nodes. Reset clears the controller state and the datapath
// control registers; in_ready is low during a build.
// Count items are taken while a result waits; encode items wait for out_ready.
module huffman_code_builder_top #(
    parameter int SYMBOLS      = 128,
    parameter int COUNT_BITS   = 16,
    parameter int MAX_CODE_LEN = 63
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic [hcb_pkg::SYM_IN_W-1:0] symbol,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hcb_pkg::CODE_W-1:0]   code_bits,
    output logic [hcb_pkg::LEN_W-1:0]    code_length
);

    hcb_pkg::dp_op_t op;
    hcb_pkg::stat_t  stat;

    // sequencer
    hcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_ready (in_ready),
        .stat     (stat),
        .op       (op)
    );

    // tables, tree memories and output register
    hcb_dp #(
        .SYMBOLS      (SYMBOLS),
        .COUNT_BITS   (COUNT_BITS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .stat        (stat),
        .symbol      (symbol),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_bits   (code_bits),
        .code_length (code_length)
    );

endmodule

### design/hcb_chk.sv
module hcb_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         kind,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [hcb_pkg::CODE_W-1:0]   code_bits,
    input logic [hcb_pkg::LEN_W-1:0]    code_length
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_bits) && $stable(code_length))
        else $error("stalled result changed");

    // no code bits without a length
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && code_length == '0 |-> code_bits == '0)
        else $error("code bits without length");

    // bits above the length stay zero
    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (code_bits >> code_length) == '0)
        else $error("code bits above length");

    // an encode item blocks input for the next cycle
    a_enc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind |=> !in_ready)
        else $error("input taken during encode");

endmodule

bind huffman_code_builder_top hcb_chk u_hcb_chk (.*);

### tb/sv/tb.sv
module tb;

    localparam int SYMS       = 128;
    localparam int CNT_MAX    = 65535;
    localparam int MAX_LEN    = 63;
    localparam int IDLE_LIMIT = 200000;
    localparam int HOLD_LEN   = 400;
    localparam int SW         = hcb_pkg::SYM_IN_W;

    typedef struct packed {
        logic [hcb_pkg::CODE_W-1:0] bits;
        logic [hcb_pkg::LEN_W-1:0]  len;
    } code_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic                         kind;
    logic [hcb_pkg::SYM_IN_W-1:0] symbol;
    logic                         last;
    logic                         out_valid;
    logic                         out_ready;
    logic [hcb_pkg::CODE_W-1:0]   code_bits;
    logic [hcb_pkg::LEN_W-1:0]    code_length;

    huffman_code_builder_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .symbol(symbol), .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .code_bits(code_bits), .code_length(code_length)
    );

    // predictor state
    int                         freq [SYMS];
    logic [hcb_pkg::CODE_W-1:0] code_tbl [SYMS];
    logic [hcb_pkg::LEN_W-1:0]  len_tbl [SYMS];
    bit                         counting;
    code_t                      code_expect_q[$];

    int  errors;
    int  codes_checked;
    int  builds_done;
    int  items_sent;
    bit  calm;          // no idling on either side
    int  hold_reqs;
    int  hold_done;
    int  hold_cnt;
    int  quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // rebuild the code table from the histogram
    function automatic void build_code_table();
        int                         wt [2*SYMS];
        int                         key [2*SYMS];
        int                         lch [2*SYMS];
        int                         rch [2*SYMS];
        int                         dep [2*SYMS];
        logic [hcb_pkg::CODE_W-1:0] cw [2*SYMS];
        int                         live[$];
        int                         nxt;
        int                         a;
        int                         b;
        int                         pos;
        for (int s = 0; s < SYMS; s++)
        begin
            code_tbl[s] = '0;
            len_tbl[s]  = '0;
        end
        // leaves enter the live list sorted by (weight, key)
        for (int s = 0; s < SYMS; s++)
        begin
            if (freq[s] != 0)
            begin
                wt[s]  = freq[s];
                key[s] = s;
                pos = live.size();
                while (pos > 0 && (wt[s] < wt[live[pos-1]] ||
                       (wt[s] == wt[live[pos-1]] && key[s] < key[live[pos-1]])))
                    pos--;
                live.insert(pos, s);
            end
        end
        nxt = SYMS;
        while (live.size() > 1)
        begin
            a = live.pop_front();
            b = live.pop_front();
            wt[nxt]  = wt[a] + wt[b];
            key[nxt] = key[a];
            lch[nxt] = a;
            rch[nxt] = b;
            // sorted insert by (weight, key), after equal entries
            pos = live.size();
            while (pos > 0 && (wt[nxt] < wt[live[pos-1]] ||
                   (wt[nxt] == wt[live[pos-1]] && key[nxt] < key[live[pos-1]])))
                pos--;
            live.insert(pos, nxt);
            nxt++;
        end
        if (nxt == SYMS)
            return;
        dep[nxt-1] = 0;
        cw[nxt-1]  = '0;
        for (int n = nxt - 1; n >= SYMS; n--)
        begin
            dep[lch[n]] = dep[n] + 1;
            cw[lch[n]]  = cw[n] << 1;
            dep[rch[n]] = dep[n] + 1;
            cw[rch[n]]  = (cw[n] << 1) | 64'd1;
        end
        for (int s = 0; s < SYMS; s++)
        begin
            if (freq[s] != 0 && dep[s] <= MAX_LEN)
            begin
                len_tbl[s]  = dep[s][hcb_pkg::LEN_W-1:0];
                code_tbl[s] = cw[s];
            end
        end
    endfunction

    // apply one accepted item to the predictor
    function automatic void predict_item(logic k, logic [hcb_pkg::SYM_IN_W-1:0] s, logic l);
        code_t c;
        if (k == 1'b0)
        begin
            if (!counting)
            begin
                for (int i = 0; i < SYMS; i++)
                    freq[i] = 0;
                counting = 1'b1;
            end
            if (freq[s] < CNT_MAX)
                freq[s]++;
            if (l)
            begin
                build_code_table();
                counting = 1'b0;
                builds_done++;
            end
        end
        else
        begin
            c.bits = code_tbl[s];
            c.len  = len_tbl[s];
            code_expect_q.push_back(c);
        end
    endfunction

    // drive one item and wait for its acceptance
    task automatic send_item(logic k, logic [hcb_pkg::SYM_IN_W-1:0] s, logic l);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 38 && gap < 6)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        symbol   <= s;
        last     <= l;
        do
            @(posedge clk);
        while (!in_ready);
        predict_item(k, s, l);
        items_sent++;
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        while (code_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic count_pass(int n, int lo, int hi);
        for (int i = 0; i < n; i++)
            send_item(1'b0, SW'($urandom_range(hi, lo)), i == n - 1);
    endtask

    // encodes before any build, and last on an encode item
    task automatic test_unbuilt_table();
        send_item(1'b1, 7'd0, 1'b0);
        send_item(1'b1, 7'd127, 1'b1);
        send_item(1'b1, 7'h55, 1'b0);
    endtask

    // a small tree with a weight tie, plus absent symbols
    task automatic test_small_tree();
        send_item(1'b0, 7'd0, 1'b0);
        send_item(1'b0, 7'd127, 1'b0);
        send_item(1'b0, 7'd127, 1'b0);
        send_item(1'b0, 7'h55, 1'b0);
        send_item(1'b0, 7'h2A, 1'b0);
        send_item(1'b1, 7'd0, 1'b0);     // encode mid-pass uses the old table
        send_item(1'b0, 7'h55, 1'b0);
        send_item(1'b0, 7'h2A, 1'b1);
        send_item(1'b1, 7'd0, 1'b0);
        send_item(1'b1, 7'd127, 1'b0);
        send_item(1'b1, 7'h55, 1'b1);
        send_item(1'b1, 7'h2A, 1'b0);
        send_item(1'b1, 7'd7, 1'b0);
    endtask

    // one symbol only: every code is empty
    task automatic test_sole_symbol();
        send_item(1'b0, 7'd5, 1'b0);
        send_item(1'b0, 7'd5, 1'b0);
        send_item(1'b0, 7'd5, 1'b1);
        send_item(1'b1, 7'd5, 1'b0);
        send_item(1'b1, 7'd6, 1'b0);
    endtask

    // symbols 9 and 2 tie on weight, key then decides; no idling here
    task automatic test_weight_tie();
        calm = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(1'b0, 7'd9, 1'b0);
        for (int i = 0; i < 12; i++)
            send_item(1'b0, 7'd2, 1'b0);
        for (int i = 0; i < 6; i++)
            send_item(1'b0, 7'd40, i == 5);
        send_item(1'b1, 7'd2, 1'b0);
        send_item(1'b1, 7'd9, 1'b0);
        send_item(1'b1, 7'd40, 1'b0);
        calm = 1'b0;
    endtask

    // receiver holds off while encodes keep coming, then sender pauses
    task automatic test_backpressure();
        count_pass(24, 0, 127);
        hold_reqs++;
        for (int i = 0; i < 30; i++)
            send_item(1'b1, SW'($urandom_range(127)), 1'b0);
        wait_results();
    endtask

    // random passes: mostly well-formed, some noise
    task automatic test_random();
        int n;
        int lo;
        int span;
        while (items_sent < 420)
        begin
            calm = (items_sent > 280 && items_sent < 360);
            n    = $urandom_range(40, 1);
            span = ($urandom_range(3) == 0) ? 127 : $urandom_range(12, 1);
            lo   = $urandom_range(127 - span);
            count_pass(n, lo, lo + span);
            repeat ($urandom_range(20, 5))
                send_item(1'b1, ($urandom_range(3) == 0) ? SW'($urandom_range(127)) :
                          SW'($urandom_range(lo + span, lo)), 1'($urandom_range(1)));
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(6, 1))
                    send_item(1'($urandom_range(1)), SW'($urandom_range(127)), 1'b0);
        end
        calm = 1'b0;
    endtask

    // receiver side: random ready with a requested long hold-off
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt - 1;
        end
        else if (hold_reqs != hold_done)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= HOLD_LEN;
            hold_done <= hold_done + 1;
        end
        else
            out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (code_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result bits=%h len=%0d",
                         $time, code_bits, code_length);
                errors++;
            end
            else
            begin
                code_t e;
                e = code_expect_q.pop_front();
                if (code_bits !== e.bits)
                begin
                    $display("%0t: code_bits expected %h actual %h",
                             $time, e.bits, code_bits);
                    errors++;
                end
                if (code_length !== e.len)
                begin
                    $display("%0t: code_length expected %0d actual %0d",
                             $time, e.len, code_length);
                    errors++;
                end
                codes_checked++;
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = 1'b0;
        symbol       = '0;
        last         = 1'b0;
        out_ready    = 1'b0;
        errors       = 0;
        codes_checked = 0;
        builds_done  = 0;
        items_sent   = 0;
        calm         = 1'b0;
        hold_reqs    = 0;
        hold_done    = 0;
        hold_cnt     = 0;
        quiet_cycles = 0;
        counting     = 1'b0;
        for (int i = 0; i < SYMS; i++)
        begin
            freq[i]     = 0;
            code_tbl[i] = '0;
            len_tbl[i]  = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unbuilt_table();
        test_small_tree();
        test_sole_symbol();
        test_backpressure();
        test_weight_tie();
        test_random();

        wait_results();
        repeat (100) @(posedge clk);
        if (code_expect_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, code_expect_q.size());
            errors++;
        end
        $display("%0d items sent, %0d code builds, %0d encode results checked",
                 items_sent, builds_done, codes_checked);
        $display("covered weight ties, sole symbol, absent symbols, hold-off stalls");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
design/hcb_pkg.sv
design/hcb_ctrl.sv
design/hcb_dp.sv
design/huffman_code_builder_top.sv
design/hcb_chk.sv
tb/sv/tb.sv
